// ----- sv/ipatc_pkg.sv -----
// ----------------------------------------------------------------------------
// ipatc_pkg
// Types and constants for the address text classifier: result codes and the
// character codes that the recognizers test against.
// ----------------------------------------------------------------------------
package ipatc_pkg;

    localparam int unsigned OUT_WIDTH = 32;   // width of each total on the port

    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_IPV4    = 2'd1,
        KIND_IPV6    = 2'd2
    } t_kind;

    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LO_F  = 8'h66;  // 'f'
    localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UP_F  = 8'h46;  // 'F'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'

    localparam logic [1:0]  V4_DOTS_FULL   = 2'd3;   // three dots in a quad
    localparam logic [1:0]  V4_DIGITS_MAX  = 2'd3;   // at most three digits per octet
    localparam logic [11:0] V4_OCTET_MAX   = 12'd255;
    localparam logic [2:0]  V6_COLONS_FULL = 3'd7;   // seven colons, no compression
    localparam logic [2:0]  V6_DIGITS_MAX  = 3'd4;   // at most four hex digits per group

endpackage

// ----- sv/ip_address_text_classifier.sv -----
// ----------------------------------------------------------------------------
// ip_address_text_classifier
// Streams address text one byte per beat and classifies each string as
// IPv4 dotted quad, full IPv6, or invalid, keeping saturating totals.
//
// Feed one byte of text per input beat (i_has_character high) and mark the
// final beat of a string with i_last_of_string; a beat with the end mark and
// no character closes the string without adding a byte. Each closing beat
// yields exactly one result beat carrying the class (0 invalid, 1 IPv4,
// 2 IPv6) and the three running totals including that string; other beats
// yield nothing. IPv4 means four decimal octets 0..255 with no leading zeros
// and three dots; IPv6 means eight groups of one to four hex digits (either
// case) and seven colons, with no "::" shortening. The empty string is
// invalid. Totals are COUNT_WIDTH bits wide, saturate at all ones, and are
// presented as their low 32 bits (zero extended when narrower). Throughput
// is one beat per clock unless a held result blocks a closing beat: the
// input register feeds a single pass of recognizer logic that writes the
// recognizer state, the counters and the result register in the same
// cycle. A held result only blocks beats that close a string; other beats
// keep flowing behind it.
// ----------------------------------------------------------------------------
module ip_address_text_classifier #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_character,
    input  logic        i_has_character,
    input  logic        i_last_of_string,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_address_kind,
    output logic [ipatc_pkg::OUT_WIDTH-1:0] o_ipv4_total,
    output logic [ipatc_pkg::OUT_WIDTH-1:0] o_ipv6_total,
    output logic [ipatc_pkg::OUT_WIDTH-1:0] o_invalid_total
);
    import ipatc_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_chr;
    logic       r_has;
    logic       r_last;

    // IPv4 recognizer
    logic       r_v4_alive,  n_v4_alive;
    logic [1:0] r_v4_dots,   n_v4_dots;
    logic [1:0] r_v4_digits, n_v4_digits;
    logic [7:0] r_v4_value,  n_v4_value;
    logic       r_v4_lz,     n_v4_lz;

    // IPv6 recognizer
    logic       r_v6_alive,  n_v6_alive;
    logic [2:0] r_v6_colons, n_v6_colons;
    logic [2:0] r_v6_digits, n_v6_digits;

    // running totals
    logic [COUNT_WIDTH-1:0] r_ipv4_cnt, n_ipv4_cnt;
    logic [COUNT_WIDTH-1:0] r_ipv6_cnt, n_ipv6_cnt;
    logic [COUNT_WIDTH-1:0] r_inv_cnt,  n_inv_cnt;

    // result register
    logic  r_out_valid;
    t_kind r_kind, n_kind;

    logic        w_adv;      // beat in the input register is consumed this cycle
    logic        w_load;     // new beat enters the input register
    logic        w_is_digit;
    logic        w_is_hex;
    logic [11:0] w_v4_sum;   // octet * 10 + digit, up to 2559

    // A closing beat needs a free result slot; anything else goes right through.
    assign w_adv   = r_in_valid && (!r_last || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !w_adv;
    assign w_load  = i_valid && !o_stall;

    assign w_is_digit = (r_chr >= CH_ZERO) && (r_chr <= CH_NINE);
    assign w_is_hex   = w_is_digit
                     || ((r_chr >= CH_LO_A) && (r_chr <= CH_LO_F))
                     || ((r_chr >= CH_UP_A) && (r_chr <= CH_UP_F));
    // x*10 = x*8 + x*2; the low nibble of an ASCII digit is its value
    assign w_v4_sum = {1'b0, r_v4_value, 3'b000} + {3'b000, r_v4_value, 1'b0}
                    + {8'h00, r_chr[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_load) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_chr  <= i_character;
            r_has  <= i_has_character;
            r_last <= i_last_of_string;
        end
    end

    // recognizers, classification and totals in one pass
    always_comb begin
        n_v4_alive  = r_v4_alive;
        n_v4_dots   = r_v4_dots;
        n_v4_digits = r_v4_digits;
        n_v4_value  = r_v4_value;
        n_v4_lz     = r_v4_lz;
        n_v6_alive  = r_v6_alive;
        n_v6_colons = r_v6_colons;
        n_v6_digits = r_v6_digits;
        n_ipv4_cnt  = r_ipv4_cnt;
        n_ipv6_cnt  = r_ipv6_cnt;
        n_inv_cnt   = r_inv_cnt;
        n_kind      = KIND_INVALID;

        // IPv4 step
        if (r_has && r_v4_alive) begin
            if (w_is_digit) begin
                if (r_v4_digits == V4_DIGITS_MAX || (r_v4_digits != 2'd0 && r_v4_lz)) begin
                    n_v4_alive = 1'b0;
                end else if (w_v4_sum > V4_OCTET_MAX) begin
                    n_v4_alive = 1'b0;
                end else begin
                    if (r_v4_digits == 2'd0) begin
                        n_v4_lz = (r_chr == CH_ZERO);
                    end
                    n_v4_value  = w_v4_sum[7:0];
                    n_v4_digits = r_v4_digits + 2'd1;
                end
            end else if (r_chr == CH_DOT) begin
                if (r_v4_digits == 2'd0 || r_v4_dots == V4_DOTS_FULL) begin
                    n_v4_alive = 1'b0;
                end else begin
                    n_v4_dots   = r_v4_dots + 2'd1;
                    n_v4_digits = 2'd0;
                    n_v4_value  = 8'd0;
                    n_v4_lz     = 1'b0;
                end
            end else begin
                n_v4_alive = 1'b0;
            end
        end

        // IPv6 step
        if (r_has && r_v6_alive) begin
            if (w_is_hex) begin
                if (r_v6_digits == V6_DIGITS_MAX) begin
                    n_v6_alive = 1'b0;
                end else begin
                    n_v6_digits = r_v6_digits + 3'd1;
                end
            end else if (r_chr == CH_COLON) begin
                if (r_v6_digits == 3'd0 || r_v6_colons == V6_COLONS_FULL) begin
                    n_v6_alive = 1'b0;
                end else begin
                    n_v6_colons = r_v6_colons + 3'd1;
                    n_v6_digits = 3'd0;
                end
            end else begin
                n_v6_alive = 1'b0;
            end
        end

        // close the string: classify on the updated state, then start over
        if (r_last) begin
            if (n_v4_alive && n_v4_dots == V4_DOTS_FULL && n_v4_digits != 2'd0) begin
                n_kind = KIND_IPV4;
                if (r_ipv4_cnt != '1) n_ipv4_cnt = r_ipv4_cnt + 1'b1;
            end else if (n_v6_alive && n_v6_colons == V6_COLONS_FULL
                         && n_v6_digits != 3'd0) begin
                n_kind = KIND_IPV6;
                if (r_ipv6_cnt != '1) n_ipv6_cnt = r_ipv6_cnt + 1'b1;
            end else begin
                n_kind = KIND_INVALID;
                if (r_inv_cnt != '1) n_inv_cnt = r_inv_cnt + 1'b1;
            end
            n_v4_alive  = 1'b1;
            n_v4_dots   = 2'd0;
            n_v4_digits = 2'd0;
            n_v4_value  = 8'd0;
            n_v4_lz     = 1'b0;
            n_v6_alive  = 1'b1;
            n_v6_colons = 3'd0;
            n_v6_digits = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4_alive  <= 1'b1;
            r_v4_dots   <= 2'd0;
            r_v4_digits <= 2'd0;
            r_v4_value  <= 8'd0;
            r_v4_lz     <= 1'b0;
            r_v6_alive  <= 1'b1;
            r_v6_colons <= 3'd0;
            r_v6_digits <= 3'd0;
            r_ipv4_cnt  <= '0;
            r_ipv6_cnt  <= '0;
            r_inv_cnt   <= '0;
        end else if (w_adv) begin
            r_v4_alive  <= n_v4_alive;
            r_v4_dots   <= n_v4_dots;
            r_v4_digits <= n_v4_digits;
            r_v4_value  <= n_v4_value;
            r_v4_lz     <= n_v4_lz;
            r_v6_alive  <= n_v6_alive;
            r_v6_colons <= n_v6_colons;
            r_v6_digits <= n_v6_digits;
            r_ipv4_cnt  <= n_ipv4_cnt;
            r_ipv6_cnt  <= n_ipv6_cnt;
            r_inv_cnt   <= n_inv_cnt;
        end
    end

    // result register; totals change only when a result loads, so they are
    // read straight from the counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_last) begin
            r_kind <= n_kind;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_address_kind  = r_kind;
    assign o_ipv4_total    = OUT_WIDTH'(r_ipv4_cnt);
    assign o_ipv6_total    = OUT_WIDTH'(r_ipv6_cnt);
    assign o_invalid_total = OUT_WIDTH'(r_inv_cnt);

`ifndef SYNTHESIS
    // a closing beat bumps at most one total, others none
    a_one_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> $countones({r_ipv4_cnt != $past(r_ipv4_cnt),
                                   r_ipv6_cnt != $past(r_ipv6_cnt),
                                   r_inv_cnt  != $past(r_inv_cnt)}) <= 1)
        else $error("more than one total changed in a cycle");

    // both recognizers restart after a string closes
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_last) |=> (r_v4_alive && r_v6_alive && r_v4_dots == 2'd0
                               && r_v4_digits == 2'd0 && r_v6_colons == 3'd0
                               && r_v6_digits == 3'd0))
        else $error("recognizer not cleared after end of string");

    // totals hold while a result is held
    a_totals_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> ($stable(r_ipv4_cnt) && $stable(r_ipv6_cnt)
                                      && $stable(r_inv_cnt)))
        else $error("totals changed under a held result");

    // a new result loads only into a free or departing slot
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_last) |-> (!r_out_valid || !i_stall))
        else $error("held result overwritten");
`endif

endmodule

// ----- test/tb_ip_address_text_classifier.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ip_address_text_classifier
// Streams address text into the classifier and checks every result beat.
// A scoreboard class runs its own IPv4/IPv6 recognizers and saturating
// totals on each accepted input beat. On every closing beat it queues the
// verdict it expects. Each accepted result beat is checked field by field
// against the oldest queued verdict. The stimulus is a directed set of
// corner strings, then random well-formed, broken and noise strings. These
// run through four phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_ip_address_text_classifier;
    import ipatc_pkg::*;

    localparam int unsigned     TOTAL_W        = 32;
    localparam longint unsigned TOTAL_MAX      = (64'd1 << TOTAL_W) - 64'd1;
    localparam int              WATCHDOG_LIMIT = 5000;  // cycles with no beat on either side
    localparam int              RANDOM_BEATS   = 1150;  // on top of the directed strings
    localparam int              NUM_PHASES     = 4;
    localparam int              MAX_PRINTED    = 50;    // mismatch lines shown before going quiet

    // One expected result beat: the class and the three totals after it.
    typedef struct {
        t_kind                 kind;
        logic [OUT_WIDTH-1:0]  ipv4_total;
        logic [OUT_WIDTH-1:0]  ipv6_total;
        logic [OUT_WIDTH-1:0]  invalid_total;
    } t_verdict;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow recognizers plus the queue of verdicts still due.
    // ------------------------------------------------------------------------
    class classifier_scoreboard;
        // dotted-quad recognizer
        bit        v4_ok;
        bit [1:0]  v4_dots;
        bit [1:0]  v4_digits;
        bit [7:0]  v4_val;
        bit        v4_lead0;
        // full IPv6 recognizer
        bit        v6_ok;
        bit [2:0]  v6_colons;
        bit [2:0]  v6_digits;
        // running totals, kept at full counter width
        longint unsigned v4_count;
        longint unsigned v6_count;
        longint unsigned bad_count;
        t_verdict  due_verdicts[$];
        int        mismatches;
        int        verdicts_seen;

        function new();
            clear_recognizers();
            v4_count      = 0;
            v6_count      = 0;
            bad_count     = 0;
            mismatches    = 0;
            verdicts_seen = 0;
        endfunction

        function void clear_recognizers();
            v4_ok     = 1'b1;
            v4_dots   = '0;
            v4_digits = '0;
            v4_val    = '0;
            v4_lead0  = 1'b0;
            v6_ok     = 1'b1;
            v6_colons = '0;
            v6_digits = '0;
        endfunction

        function longint unsigned bump(longint unsigned c);
            return (c >= TOTAL_MAX) ? TOTAL_MAX : c + 64'd1;
        endfunction

        function void feed_v4(bit [7:0] ch);
            int unsigned acc;
            if (!v4_ok)
                return;
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                acc = 32'(v4_val) * 10 + 32'(ch - CH_ZERO);
                // fourth digit, digit after a lone zero, or value above 255
                if (v4_digits == V4_DIGITS_MAX || (v4_digits != 0 && v4_lead0)) begin
                    v4_ok = 1'b0;
                end else if (acc > 255) begin
                    v4_ok = 1'b0;
                end else begin
                    if (v4_digits == 0)
                        v4_lead0 = (ch == CH_ZERO);
                    v4_val = acc[7:0];
                    v4_digits++;
                end
            end else if (ch == CH_DOT) begin
                if (v4_digits == 0 || v4_dots == V4_DOTS_FULL) begin
                    v4_ok = 1'b0;
                end else begin
                    v4_dots++;
                    v4_digits = '0;
                    v4_val    = '0;
                    v4_lead0  = 1'b0;
                end
            end else begin
                v4_ok = 1'b0;
            end
        endfunction

        function void feed_v6(bit [7:0] ch);
            bit hex;
            hex = (ch >= CH_ZERO && ch <= CH_NINE) || (ch >= CH_LO_A && ch <= CH_LO_F) ||
                  (ch >= CH_UP_A && ch <= CH_UP_F);
            if (!v6_ok)
                return;
            if (hex) begin
                if (v6_digits == V6_DIGITS_MAX)
                    v6_ok = 1'b0;
                else
                    v6_digits++;
            end else if (ch == CH_COLON) begin
                if (v6_digits == 0 || v6_colons == V6_COLONS_FULL) begin
                    v6_ok = 1'b0;
                end else begin
                    v6_colons++;
                    v6_digits = '0;
                end
            end else begin
                v6_ok = 1'b0;
            end
        endfunction

        // Called for every accepted input beat, in order.
        function void absorb_beat(bit [7:0] ch, bit has, bit last);
            t_verdict v;
            if (has) begin
                feed_v4(ch);
                feed_v6(ch);
            end
            if (!last)
                return;
            if (v4_ok && v4_dots == V4_DOTS_FULL && v4_digits != 0) begin
                v.kind   = KIND_IPV4;
                v4_count = bump(v4_count);
            end else if (v6_ok && v6_colons == V6_COLONS_FULL && v6_digits != 0) begin
                v.kind   = KIND_IPV6;
                v6_count = bump(v6_count);
            end else begin
                v.kind    = KIND_INVALID;
                bad_count = bump(bad_count);
            end
            v.ipv4_total    = v4_count[OUT_WIDTH-1:0];
            v.ipv6_total    = v6_count[OUT_WIDTH-1:0];
            v.invalid_total = bad_count[OUT_WIDTH-1:0];
            due_verdicts.push_back(v);
            clear_recognizers();
        endfunction

        function int pending();
            return due_verdicts.size();
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // Called for every accepted result beat.
        task check_verdict(logic [1:0] kind, logic [OUT_WIDTH-1:0] t4,
                           logic [OUT_WIDTH-1:0] t6, logic [OUT_WIDTH-1:0] tbad);
            t_verdict w;
            if (due_verdicts.size() == 0) begin
                report($sformatf("result beat with nothing due (kind %0d)", kind));
                return;
            end
            w = due_verdicts.pop_front();
            verdicts_seen++;
            if (kind !== w.kind)
                report($sformatf("verdict %0d kind: got %0d, want %0d",
                                 verdicts_seen, kind, w.kind));
            if (t4 !== w.ipv4_total)
                report($sformatf("verdict %0d ipv4_total: got %0d, want %0d",
                                 verdicts_seen, t4, w.ipv4_total));
            if (t6 !== w.ipv6_total)
                report($sformatf("verdict %0d ipv6_total: got %0d, want %0d",
                                 verdicts_seen, t6, w.ipv6_total));
            if (tbad !== w.invalid_total)
                report($sformatf("verdict %0d invalid_total: got %0d, want %0d",
                                 verdicts_seen, tbad, w.invalid_total));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_valid          = 1'b0;
    logic [7:0]           i_character      = 8'h00;
    logic                 i_has_character  = 1'b0;
    logic                 i_last_of_string = 1'b0;
    logic                 i_stall          = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [1:0]           o_address_kind;
    logic [OUT_WIDTH-1:0] o_ipv4_total;
    logic [OUT_WIDTH-1:0] o_ipv6_total;
    logic [OUT_WIDTH-1:0] o_invalid_total;

    ip_address_text_classifier #(
        .COUNT_WIDTH (TOTAL_W)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_character      (i_character),
        .i_has_character  (i_has_character),
        .i_last_of_string (i_last_of_string),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_address_kind   (o_address_kind),
        .o_ipv4_total     (o_ipv4_total),
        .o_ipv6_total     (o_ipv6_total),
        .o_invalid_total  (o_invalid_total)
    );

    classifier_scoreboard sb;

    int         send_idle_pct = 0;   // chance the sender skips a cycle
    int         stall_pct     = 0;   // chance the receiver stalls a cycle
    int         text_beats    = 0;   // beats carrying a byte or an end mark
    int         strings_sent  = 0;
    int         quiet_cycles  = 0;
    bit [7:0]   txt[$];              // string being built for the next send

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: stall decided once per cycle at the falling edge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Result monitor. Inputs only move at the falling edge, so the values
    // seen here are the ones the DUT saw at this rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0)
            sb.check_verdict(o_address_kind, o_ipv4_total, o_ipv6_total, o_invalid_total);
    end

    // Watchdog: any beat on either channel resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no beat for %0d cycles, %0d verdicts still due",
                         WATCHDOG_LIMIT, sb.pending());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Present one input beat and hold it until it is taken. Idle cycles are
    // inserted at random ahead of it, so gaps land mid-string and before the
    // end mark as well as between strings.
    task automatic send_beat(input bit [7:0] ch, input bit has, input bit last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_character      <= ch;
        i_has_character  <= has;
        i_last_of_string <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.absorb_beat(ch, has, last);
        if (has || last)
            text_beats++;
    endtask

    // Drop valid and hold off until every due verdict has come back.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Send txt as one string. The end mark rides on the last byte, or on a
    // separate byte-less beat; an empty string always takes the latter.
    // Now and then a beat with neither a byte nor an end mark slips in.
    task automatic send_text(input bit end_apart);
        int n;
        n = txt.size();
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 3)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_beat(txt[k], 1'b1, (!end_apart && k == n - 1));
        end
        if (end_apart || n == 0)
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        strings_sent++;
    endtask

    function automatic void load_text(string s);
        txt.delete();
        for (int k = 0; k < s.len(); k++)
            txt.push_back(s[k]);
    endfunction

    task automatic send_directed(string s, bit end_apart);
        load_text(s);
        send_text(end_apart);
    endtask

    // ------------------------------------------------------------------------
    // Random string builders
    // ------------------------------------------------------------------------
    function automatic bit [7:0] pick_char();
        case ($urandom_range(0, 5))
            0:       return 8'(CH_ZERO + $urandom_range(0, 9));
            1:       return CH_DOT;
            2:       return CH_COLON;
            3:       return 8'(CH_LO_A + $urandom_range(0, 6));  // 'g' is just outside hex
            4:       return 8'(CH_UP_A + $urandom_range(0, 6));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void append_dec(int v);
        if (v >= 100)
            txt.push_back(8'(CH_ZERO + v / 100));
        if (v >= 10)
            txt.push_back(8'(CH_ZERO + (v / 10) % 10));
        txt.push_back(8'(CH_ZERO + v % 10));
    endfunction

    function automatic void build_v4();
        int v;
        for (int o = 0; o < 4; o++) begin
            if (o != 0)
                txt.push_back(CH_DOT);
            case ($urandom_range(0, 5))
                0:       v = 0;
                1:       v = 255;
                2:       v = $urandom_range(250, 255);
                3:       v = $urandom_range(200, 249);
                4:       v = $urandom_range(0, 9);
                default: v = $urandom_range(0, 255);
            endcase
            append_dec(v);
        end
    endfunction

    function automatic void build_v6();
        int d;
        for (int g = 0; g < 8; g++) begin
            if (g != 0)
                txt.push_back(CH_COLON);
            repeat ($urandom_range(1, 4)) begin
                d = $urandom_range(0, 15);
                if (d < 10)
                    txt.push_back(8'(CH_ZERO + d));
                else if ($urandom_range(0, 1))
                    txt.push_back(8'(CH_LO_A + d - 10));
                else
                    txt.push_back(8'(CH_UP_A + d - 10));
            end
        end
    endfunction

    // Break a well-formed string: swap, drop, insert or repeat a byte, cut the
    // tail, or tack on more. This yields extra separators, empty fields,
    // fifth hex digits, leading zeros, big octets and stray bytes.
    function automatic void mutate();
        int pos;
        if (txt.size() == 0) begin
            txt.push_back(pick_char());
            return;
        end
        pos = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 5))
            0: txt[pos] = 8'($urandom_range(0, 255));
            1: txt.delete(pos);
            2: txt.insert(pos, pick_char());
            3: txt.insert(pos, txt[pos]);
            4: while (txt.size() > pos) void'(txt.pop_back());
            default: repeat ($urandom_range(1, 4)) txt.push_back(pick_char());
        endcase
    endfunction

    task automatic send_random_string();
        int pick;
        txt.delete();
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            build_v4();
        end else if (pick < 66) begin
            build_v6();
        end else if (pick < 88) begin
            if ($urandom_range(0, 1))
                build_v4();
            else
                build_v6();
            repeat ($urandom_range(1, 2)) mutate();
        end else begin
            repeat ($urandom_range(0, 12)) txt.push_back(pick_char());
        end
        send_text($urandom_range(0, 99) < 30);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int idle_by_phase[NUM_PHASES];
        int stall_by_phase[NUM_PHASES];
        int beat_goal;

        idle_by_phase  = '{0, 75, 0, 28};
        stall_by_phase = '{0, 0, 75, 28};
        sb = new();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners, no idling. A beat with neither byte nor end mark
        // comes first: it must leave no trace.
        send_beat(8'h00, 1'b0, 1'b0);
        send_directed("0.0.0.0", 1'b0);
        send_directed("255.255.255.255", 1'b1);
        send_directed("249.250.199.100", 1'b0);
        send_directed("256.1.1.1", 1'b0);        // octet above 255
        send_directed("1234.1.1.1", 1'b0);       // four-digit octet
        send_directed("01.2.3.4", 1'b0);         // leading zero
        send_directed("1..2.3", 1'b0);           // empty octet
        send_directed("1.2.3.4.", 1'b1);         // extra dot
        send_directed("1.2.3", 1'b0);
        send_directed("a.b.c.d", 1'b0);
        send_directed("0:0:0:0:0:0:0:0", 1'b0);
        send_directed("ffff:FFFF:abcd:ABCD:0123:4567:89aB:cDeF", 1'b1);
        send_directed("12345:0:0:0:0:0:0:0", 1'b0);  // fifth hex digit
        send_directed("1::2:3:4:5:6:7", 1'b0);       // compression is not allowed
        send_directed("1:2:3:4:5:6:7:8:", 1'b0);     // extra colon
        send_directed("1:2:3:4:5:6:7:8:9", 1'b0);
        send_directed("g:0:0:0:0:0:0:0", 1'b0);
        send_directed("", 1'b1);                     // empty string
        // bytes outside both alphabets: NUL and all-ones
        load_text("1.2.3.4");
        txt.push_back(8'h00);
        send_text(1'b0);
        load_text("1:2:3:4:5:6:7:8");
        txt.insert(4, 8'hFF);
        send_text(1'b1);
        drain();

        // Random strings across the idle/stall phases; each phase ends with
        // the sender holding off until all verdicts are back.
        beat_goal = text_beats;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct = idle_by_phase[ph];
            stall_pct     = stall_by_phase[ph];
            beat_goal    += RANDOM_BEATS / NUM_PHASES;
            while (text_beats < beat_goal)
                send_random_string();
            drain();
        end

        // Let any stray result beat surface before judging.
        repeat (8) @(posedge i_clk);

        $display("Sent %0d strings in %0d beats; verdicts: %0d IPv4, %0d IPv6, %0d invalid",
                 strings_sent, text_beats, sb.v4_count, sb.v6_count, sb.bad_count);
        $display("Phases: no idling, sender idle 75%%, receiver stall 75%%, both 28%%; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/ipatc_pkg.sv
sv/ip_address_text_classifier.sv
test/tb_ip_address_text_classifier.sv
